// ----- design/swsr_pkg.sv -----
// Shared widths, constants, register and signal codes and the window result
// bundle for the moving average and strength index block. No dependencies.
package swsr_pkg;

  localparam int PRICE_W    = 24;  // price samples and buy price
  localparam int PER_W      = 7;   // averaging and index periods
  localparam int LVL_W      = 14;  // index and threshold levels, hundredths
  localparam int SUM_W      = 31;  // window sums
  localparam int RSI_DEN_W  = 32;  // gain sum plus loss sum
  localparam int RSI_NUM_W  = 45;  // gain sum times scale
  localparam int PCT_NUM_W  = 38;  // price difference times scale

  typedef enum logic [2:0] {
    CFG_SMA_PERIOD       = 3'd0,
    CFG_RSI_PERIOD       = 3'd1,
    CFG_OVERSOLD_LEVEL   = 3'd2,
    CFG_OVERBOUGHT_LEVEL = 3'd3,
    CFG_BUY_PRICE        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {SIG_HOLD = 2'd0, SIG_BUY = 2'd1, SIG_SELL = 2'd2} signal_e;

  // Results of one ring sweep, held stable until the next sweep starts.
  typedef struct packed {
    logic [SUM_W-1:0] price_sum;
    logic [SUM_W-1:0] gain_sum;
    logic [SUM_W-1:0] loss_sum;
    logic [PER_W-1:0] navg;
    logic             rsi_ready;
  } win_res_t;

endpackage

// ----- design/swsr_div.sv -----
// Restoring divider, one quotient bit per cycle through a shift register.
// Uses no package.
module swsr_div #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // The dividend drains out of the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
      dvs_q  <= divisor_i;
      rem_q  <= '0;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/swsr_window.sv -----
// Price, gain and loss rings with the sweep that totals the newest entries.
// Depends on swsr_pkg for widths and the result bundle.
module swsr_window import swsr_pkg::*; #(
  parameter int WINDOW = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic [PER_W-1:0]   sma_period_i,
  input  logic [PER_W-1:0]   rsi_period_i,
  output logic               done_o,
  output win_res_t           res_o
);

  localparam int AW    = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > PER_W) ? CNT_W : PER_W;

  typedef enum logic [1:0] {W_IDLE, W_SWEEP, W_DRAIN, W_FINISH} wstate_e;

  wstate_e            state_q;
  logic [AW-1:0]      wr_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic [PRICE_W-1:0] prev_q;
  logic [AW-1:0]      rd_addr_q;
  logic [PER_W-1:0]   issue_q;
  logic [PER_W-1:0]   span_q;
  logic [PER_W-1:0]   tag_q;
  logic               tag_vld_q;
  logic [PER_W-1:0]   navg_q;
  logic [PER_W-1:0]   nidx_q;
  logic               rsi_ready_q;
  logic [SUM_W-1:0]   price_sum_q;
  logic [SUM_W-1:0]   gain_sum_q;
  logic [SUM_W-1:0]   loss_sum_q;

  logic [PRICE_W-1:0] price_ring_q [WINDOW];
  logic [PRICE_W-1:0] gain_ring_q  [WINDOW];
  logic [PRICE_W-1:0] loss_ring_q  [WINDOW];
  logic [PRICE_W-1:0] rd_price_q;
  logic [PRICE_W-1:0] rd_gain_q;
  logic [PRICE_W-1:0] rd_loss_q;

  logic               take;
  logic [PRICE_W-1:0] gain_w;
  logic [PRICE_W-1:0] loss_w;
  logic [CNT_W-1:0]   count_nxt;
  logic [CMP_W-1:0]   cnt_ext;
  logic [PER_W-1:0]   navg_w;
  logic [PER_W-1:0]   nidx_w;
  logic [PER_W-1:0]   span_w;
  logic               rsi_ready_w;
  logic [AW-1:0]      wr_ptr_nxt;
  logic [AW-1:0]      rd_addr_dec;

  assign take = start_i && (state_q == W_IDLE);

  // The first sample after reset has no predecessor, so no rise and no fall.
  always_comb begin
    gain_w = '0;
    loss_w = '0;
    if (count_q != '0) begin
      if (price_i > prev_q) begin
        gain_w = price_i - prev_q;
      end else begin
        loss_w = prev_q - price_i;
      end
    end
  end

  assign count_nxt   = (count_q == CNT_W'(WINDOW)) ? count_q : count_q + CNT_W'(1);
  assign cnt_ext     = CMP_W'(count_nxt);
  assign navg_w      = (CMP_W'(sma_period_i) < cnt_ext) ? sma_period_i : PER_W'(count_nxt);
  assign nidx_w      = (CMP_W'(rsi_period_i) < cnt_ext) ? rsi_period_i : PER_W'(count_nxt);
  assign span_w      = (navg_w > nidx_w) ? navg_w : nidx_w;
  assign rsi_ready_w = cnt_ext > CMP_W'(rsi_period_i);
  assign wr_ptr_nxt  = (wr_ptr_q == AW'(WINDOW - 1)) ? '0 : wr_ptr_q + AW'(1);
  assign rd_addr_dec = (rd_addr_q == '0) ? AW'(WINDOW - 1) : rd_addr_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (take) begin
      price_ring_q[wr_ptr_q] <= price_i;
      gain_ring_q[wr_ptr_q]  <= gain_w;
      loss_ring_q[wr_ptr_q]  <= loss_w;
    end
    rd_price_q <= price_ring_q[rd_addr_q];
    rd_gain_q  <= gain_ring_q[rd_addr_q];
    rd_loss_q  <= loss_ring_q[rd_addr_q];
  end

  // The sweep walks back from the newest slot; read data lands in the next cycle,
  // together with its tag, which says which totals it belongs to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_IDLE;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      prev_q      <= '0;
      rd_addr_q   <= '0;
      issue_q     <= '0;
      span_q      <= '0;
      tag_q       <= '0;
      tag_vld_q   <= 1'b0;
      navg_q      <= '0;
      nidx_q      <= '0;
      rsi_ready_q <= 1'b0;
      price_sum_q <= '0;
      gain_sum_q  <= '0;
      loss_sum_q  <= '0;
    end else begin
      if (tag_vld_q) begin
        if (tag_q < navg_q) begin
          price_sum_q <= price_sum_q + SUM_W'(rd_price_q);
        end
        if (tag_q < nidx_q) begin
          gain_sum_q <= gain_sum_q + SUM_W'(rd_gain_q);
          loss_sum_q <= loss_sum_q + SUM_W'(rd_loss_q);
        end
      end
      case (state_q)
        W_IDLE: begin
          if (start_i) begin
            wr_ptr_q    <= wr_ptr_nxt;
            count_q     <= count_nxt;
            prev_q      <= price_i;
            rd_addr_q   <= wr_ptr_q;
            issue_q     <= '0;
            span_q      <= span_w;
            navg_q      <= navg_w;
            nidx_q      <= nidx_w;
            rsi_ready_q <= rsi_ready_w;
            price_sum_q <= '0;
            gain_sum_q  <= '0;
            loss_sum_q  <= '0;
            state_q     <= (span_w == '0) ? W_FINISH : W_SWEEP;
          end
        end
        W_SWEEP: begin
          tag_q     <= issue_q;
          tag_vld_q <= 1'b1;
          issue_q   <= issue_q + PER_W'(1);
          rd_addr_q <= rd_addr_dec;
          if (issue_q == span_q - PER_W'(1)) begin
            state_q <= W_DRAIN;
          end
        end
        W_DRAIN: begin
          tag_vld_q <= 1'b0;
          state_q   <= W_FINISH;
        end
        W_FINISH: begin
          state_q <= W_IDLE;
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

  assign done_o          = (state_q == W_FINISH);
  assign res_o.price_sum = price_sum_q;
  assign res_o.gain_sum  = gain_sum_q;
  assign res_o.loss_sum  = loss_sum_q;
  assign res_o.navg      = navg_q;
  assign res_o.rsi_ready = rsi_ready_q;

endmodule

// ----- design/sliding_window_sma_rsi.sv -----
// Moving average, relative strength index, trade signal and percent gain
// for one price stream. Top level; uses swsr_pkg, swsr_window and swsr_div.
//
// Usage: each word on the input channel is one price in hundredths, taken
// when in_valid_i is high and in_stall_o is low. Each price gives exactly
// one result word on the output channel, taken when out_valid_o is high and
// out_stall_i is low. Configuration words (period, level and buy price
// registers, by index) are taken whenever cfg_valid_i is high; write them
// only while no price is in flight.
// Timing: one price is worked on at a time. With S the longer of the two
// spans (each period capped by the samples seen so far), the ring sweep
// reads S entries, one entry per cycle, and the three serial dividers then
// run together until the one with the widest dividend is done. No price is
// taken before the result is registered; the next can be taken in the
// cycle after.
// A result sits in the output register while the next price is already
// being processed; only a finished result that finds the register still
// full and stalled holds the block up.
// Reset returns the registers to their defaults and empties the history;
// ring contents are not cleared, since only written entries are ever read.
module sliding_window_sma_rsi import swsr_pkg::*; #(
  parameter int WINDOW = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [PRICE_W-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [PRICE_W-1:0]        price_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [PRICE_W-1:0]        moving_average_o,
  output logic [LVL_W-1:0]          strength_index_o,
  output logic [1:0]                signal_o,
  output logic signed [PRICE_W-1:0] gain_percent_o
);

  typedef enum logic [2:0] {T_IDLE, T_SWEEP, T_LAUNCH, T_DIVIDE, T_RESULT} tstate_e;

  localparam logic [PER_W-1:0]   SMA_RESET        = 7'd5;
  localparam logic [PER_W-1:0]   RSI_RESET        = 7'd14;
  localparam logic [LVL_W-1:0]   OVERSOLD_RESET   = 14'd3000;
  localparam logic [LVL_W-1:0]   OVERBOUGHT_RESET = 14'd7000;
  localparam logic [LVL_W-1:0]   SCALE            = 14'd10000;
  localparam logic [LVL_W-1:0]   RSI_NEUTRAL      = 14'd5000;
  localparam logic [LVL_W-1:0]   RSI_FULL         = 14'd10000;
  localparam logic [PRICE_W-1:0] PCT_MAX          = 24'h7FFFFF;

  logic [PER_W-1:0]   sma_period_q;
  logic [PER_W-1:0]   rsi_period_q;
  logic [LVL_W-1:0]   oversold_q;
  logic [LVL_W-1:0]   overbought_q;
  logic [PRICE_W-1:0] buy_price_q;

  tstate_e              state_q;
  logic [PRICE_W-1:0]   px_q;
  logic [PRICE_W-1:0]   pct_mag_q;
  logic                 pct_neg_q;
  logic [RSI_NUM_W-1:0] rsi_num_q;
  logic [RSI_DEN_W-1:0] rsi_den_q;
  logic [PCT_NUM_W-1:0] pct_num_q;
  logic                 out_valid_q;
  logic [PRICE_W-1:0]   avg_out_q;
  logic [LVL_W-1:0]     idx_out_q;
  logic [1:0]           sig_out_q;
  logic [PRICE_W-1:0]   pct_out_q;

  logic                 win_start;
  logic                 win_done;
  win_res_t             win_res;
  logic                 div_start;
  logic                 avg_busy;
  logic                 rsi_busy;
  logic                 pct_busy;
  logic [SUM_W-1:0]     avg_quo;
  logic [RSI_NUM_W-1:0] rsi_quo;
  logic [PCT_NUM_W-1:0] pct_quo;

  logic [PRICE_W-1:0]   avg_w;
  logic [LVL_W-1:0]     idx_w;
  signal_e              sig_w;
  logic [PRICE_W-1:0]   pct_w;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sma_period_q <= SMA_RESET;
      rsi_period_q <= RSI_RESET;
      oversold_q   <= OVERSOLD_RESET;
      overbought_q <= OVERBOUGHT_RESET;
      buy_price_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SMA_PERIOD:       sma_period_q <= cfg_data_i[PER_W-1:0];
        CFG_RSI_PERIOD:       rsi_period_q <= cfg_data_i[PER_W-1:0];
        CFG_OVERSOLD_LEVEL:   oversold_q   <= cfg_data_i[LVL_W-1:0];
        CFG_OVERBOUGHT_LEVEL: overbought_q <= cfg_data_i[LVL_W-1:0];
        CFG_BUY_PRICE:        buy_price_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != T_IDLE);
  assign win_start  = in_valid_i && (state_q == T_IDLE);
  assign div_start  = (state_q == T_LAUNCH);

  swsr_window #(.WINDOW(WINDOW)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (win_start),
    .price_i      (price_i),
    .sma_period_i (sma_period_q),
    .rsi_period_i (rsi_period_q),
    .done_o       (win_done),
    .res_o        (win_res)
  );

  swsr_div #(.DVD_W(SUM_W), .DVS_W(PER_W)) u_avg_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (win_res.price_sum),
    .divisor_i  (win_res.navg),
    .busy_o     (avg_busy),
    .quotient_o (avg_quo)
  );

  swsr_div #(.DVD_W(RSI_NUM_W), .DVS_W(RSI_DEN_W)) u_rsi_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rsi_num_q),
    .divisor_i  (rsi_den_q),
    .busy_o     (rsi_busy),
    .quotient_o (rsi_quo)
  );

  swsr_div #(.DVD_W(PCT_NUM_W), .DVS_W(PRICE_W)) u_pct_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pct_num_q),
    .divisor_i  (buy_price_q),
    .busy_o     (pct_busy),
    .quotient_o (pct_quo)
  );

  // Final selection of the special cases around the divider results.
  always_comb begin
    avg_w = (win_res.navg == '0) ? px_q : avg_quo[PRICE_W-1:0];

    if (!win_res.rsi_ready) begin
      idx_w = RSI_NEUTRAL;
    end else if (win_res.loss_sum == '0) begin
      idx_w = RSI_FULL;
    end else begin
      idx_w = rsi_quo[LVL_W-1:0];
    end

    if (idx_w < oversold_q) begin
      sig_w = SIG_BUY;
    end else if (idx_w > overbought_q) begin
      sig_w = SIG_SELL;
    end else begin
      sig_w = SIG_HOLD;
    end

    // A loss never exceeds the full buy price, so its magnitude stays small.
    if (buy_price_q == '0) begin
      pct_w = '0;
    end else if (pct_neg_q) begin
      pct_w = '0 - pct_quo[PRICE_W-1:0];
    end else if (pct_quo > PCT_NUM_W'(PCT_MAX)) begin
      pct_w = PCT_MAX;
    end else begin
      pct_w = pct_quo[PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      px_q        <= '0;
      pct_mag_q   <= '0;
      pct_neg_q   <= 1'b0;
      rsi_num_q   <= '0;
      rsi_den_q   <= '0;
      pct_num_q   <= '0;
      out_valid_q <= 1'b0;
      avg_out_q   <= '0;
      idx_out_q   <= '0;
      sig_out_q   <= '0;
      pct_out_q   <= '0;
    end else begin
      // In the result state the output register is either loaded or held.
      if (!out_stall_i && (state_q != T_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_valid_i) begin
            px_q      <= price_i;
            pct_neg_q <= price_i < buy_price_q;
            pct_mag_q <= (price_i < buy_price_q) ? buy_price_q - price_i
                                                 : price_i - buy_price_q;
            state_q   <= T_SWEEP;
          end
        end
        T_SWEEP: begin
          if (win_done) begin
            rsi_num_q <= RSI_NUM_W'(win_res.gain_sum) * RSI_NUM_W'(SCALE);
            rsi_den_q <= RSI_DEN_W'(win_res.gain_sum) + RSI_DEN_W'(win_res.loss_sum);
            pct_num_q <= PCT_NUM_W'(pct_mag_q) * PCT_NUM_W'(SCALE);
            state_q   <= T_LAUNCH;
          end
        end
        T_LAUNCH: begin
          state_q <= T_DIVIDE;
        end
        T_DIVIDE: begin
          if (!avg_busy && !rsi_busy && !pct_busy) begin
            state_q <= T_RESULT;
          end
        end
        T_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            avg_out_q   <= avg_w;
            idx_out_q   <= idx_w;
            sig_out_q   <= sig_w;
            pct_out_q   <= pct_w;
            state_q     <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign moving_average_o = avg_out_q;
  assign strength_index_o = idx_out_q;
  assign signal_o         = sig_out_q;
  assign gain_percent_o   = $signed(pct_out_q);

  // The window only finishes a sweep that the controller is waiting for.
  a_done_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done |-> state_q == T_SWEEP)
    else $error("window sweep finished outside the sweep state");

  // The dividers run only during the divide phase.
  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avg_busy || rsi_busy || pct_busy) |-> state_q == T_DIVIDE)
    else $error("divider busy outside the divide phase");

  // An accepted price always starts a sweep in the next cycle.
  a_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == T_SWEEP)
    else $error("accepted price did not start a sweep");

  // A delivered index never exceeds full scale.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> strength_index_o <= RSI_FULL)
    else $error("strength index above full scale");

endmodule
